// ----- sv/ier_pkg.sv -----
// Shared constants, types and helpers for the ICMP echo reply rewriter.
// No dependencies; every module of the block and the bench import this package.
package ier_pkg;

	// Packet limits in bytes
	localparam int MAX_BYTES = 256;
	localparam int MIN_BYTES = 24;

	// Widths: byte count, store index per bank, store address over two banks
	localparam int CNT_W   = 9;
	localparam int IDX_W   = 6;
	localparam int ADDR_W  = IDX_W + 1;
	localparam int DEPTH   = 1 << ADDR_W;
	localparam int IPS_W   = 20;
	localparam int ICS_W   = 24;

	// Word positions inside the packet
	localparam logic [IDX_W-1:0] HDR_WORDS     = IDX_W'(5);
	localparam logic [IDX_W-1:0] IP_CSUM_WORD  = IDX_W'(2);
	localparam logic [IDX_W-1:0] SRC_WORD      = IDX_W'(3);
	localparam logic [IDX_W-1:0] DST_WORD      = IDX_W'(4);
	localparam logic [IDX_W-1:0] ICMP_HDR_WORD = IDX_W'(5);

	// Result status codes
	localparam logic [1:0] ST_REPLY = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_LONG  = 2'd2;

	// Finished packet handed from front to back
	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] nbytes;
		logic [1:0]       status;
		logic [IPS_W-1:0] ip_sum;
		logic [ICS_W-1:0] icmp_sum;
	} desc_t;

	// Store write and read requests
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       data;
	} mem_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} mem_rd_t;

	// Back tells front that a bank may be refilled
	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	// Keep the first nb bytes of a word, clear the rest
	function automatic logic [31:0] mask_bytes(input logic [31:0] w, input logic [2:0] nb);
		logic [31:0] r;
		case (nb)
			3'd0:    r = 32'h0;
			3'd1:    r = w & 32'hFF00_0000;
			3'd2:    r = w & 32'hFFFF_0000;
			3'd3:    r = w & 32'hFFFF_FF00;
			default: r = w;
		endcase
		return r;
	endfunction

	// Fold a ones' complement sum to 16 bits and invert it
	function automatic logic [15:0] csum_fold(input logic [ICS_W-1:0] s);
		logic [16:0] a;
		logic [16:0] b;
		a = {1'b0, s[15:0]} + {9'b0, s[23:16]};
		b = {1'b0, a[15:0]} + {16'b0, a[16]};
		return ~b[15:0];
	endfunction

endpackage

// ----- sv/ier_in_if.sv -----
// Request channel of the rewriter: one packet word per transfer.
// Standalone interface, no dependencies.
interface ier_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] in_word;
	logic [2:0]  in_bytes;
	logic        in_last;

	modport source (output valid, in_word, in_bytes, in_last, input ready);
	modport sink   (input valid, in_word, in_bytes, in_last, output ready);
endinterface

// ----- sv/ier_out_if.sv -----
// Result channel of the rewriter: one reply word or one drop per transfer.
// Standalone interface, no dependencies.
interface ier_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_word;
	logic [2:0]  out_bytes;
	logic        out_last;
	logic [1:0]  out_status;

	modport source (output valid, out_word, out_bytes, out_last, out_status, input ready);
	modport sink   (input valid, out_word, out_bytes, out_last, out_status, output ready);
endinterface

// ----- sv/icmp_echo_reply_rewriter.sv -----
// Top level of the ICMP echo reply rewriter: front, queue, store and back.
// Depends on ier_pkg, ier_in_if, ier_out_if and all ier_* modules.
//
//  channel  side    payload                                    per request
//  echo     sink    in_word, in_bytes, in_last                 one packet word
//  reply    source  out_word, out_bytes, out_last, out_status  one reply word or one drop
//
// Loading takes one word per cycle while echo.ready is high; a packet's reply words follow at one
// per cycle while reply.ready is high, once the packet's last word has been loaded.
// These rates are set by the single store write port and the replay through the read port.
// Two store banks let the next packet load while the previous one is replayed.
// Reset clears all control state; store contents are undefined and are never read unwritten.
// Either side may stall at any time; a held result does not block loading the next packet.
module icmp_echo_reply_rewriter
	import ier_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	ier_in_if.sink    echo,
	ier_out_if.source reply
);

	logic        push;
	desc_t       push_desc;
	logic        q_full;
	logic        q_valid;
	desc_t       q_head;
	logic        q_pop;
	mem_wr_t     wr;
	mem_rd_t     rd;
	logic [31:0] rd_data;
	release_t    rel;

	ier_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.echo   (echo),
		.q_full (q_full),
		.rel    (rel),
		.push   (push),
		.desc   (push_desc),
		.wr     (wr)
	);

	ier_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	ier_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	ier_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.rd      (rd),
		.rd_data (rd_data),
		.rel     (rel),
		.reply   (reply)
	);

endmodule

// ----- sv/ier_ram.sv -----
// Two-bank packet store, one write port and one registered read port.
// Depends on ier_pkg.
module ier_ram
	import ier_pkg::*;
(
	input  logic        clk,
	input  mem_wr_t     wr,
	input  mem_rd_t     rd,
	output logic [31:0] rd_data
);

	logic [31:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

// ----- sv/ier_front.sv -----
// Front part: accepts packet words, stores them and accumulates both sums.
// Depends on ier_pkg and ier_in_if; feeds ier_queue and ier_ram.
module ier_front
	import ier_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	ier_in_if.sink   echo,
	input  logic     q_full,
	input  release_t rel,
	output logic     push,
	output desc_t    desc,
	output mem_wr_t  wr
);

	logic             bank_q;
	logic [1:0]       busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IPS_W-1:0] ip_q;
	logic [ICS_W-1:0] icmp_q;
	logic             ovf_q;

	logic             acc;
	logic [2:0]       nb;
	logic [CNT_W:0]   cnt_sum;
	logic             fits;
	logic             take;
	logic             set_ovf;
	logic [31:0]      w;
	logic [CNT_W-3:0] widx;
	logic [16:0]      halves;
	logic [IPS_W-1:0] ip_add;
	logic [ICS_W-1:0] icmp_add;
	logic [CNT_W-1:0] cnt_nx;
	logic [IPS_W-1:0] ip_nx;
	logic [ICS_W-1:0] icmp_nx;
	logic             ovf_nx;
	logic [1:0]       busy_nx;

	// Accept while the queue has room and the bank being filled is free
	assign echo.ready = !q_full && !busy_q[bank_q];
	assign acc        = echo.valid && echo.ready;

	// Byte count of this word
	always_comb begin
		nb = 3'd4;
		if (echo.in_last) begin
			nb = (echo.in_bytes > 3'd4) ? 3'd4 : echo.in_bytes;
		end
	end

	assign cnt_sum = {1'b0, cnt_q} + {(CNT_W-2)'(0), nb};
	assign fits    = cnt_sum <= (CNT_W+1)'(MAX_BYTES);
	assign take    = !ovf_q && (nb != 3'd0) && fits;
	assign set_ovf = !ovf_q && (nb != 3'd0) && !fits;
	assign w       = mask_bytes(echo.in_word, nb);
	assign widx    = cnt_q[CNT_W-1:2];
	assign halves  = {1'b0, w[31:16]} + {1'b0, w[15:0]};

	// Sum contributions: header skips its checksum, ICMP skips type and checksum
	always_comb begin
		ip_add   = '0;
		icmp_add = '0;
		if (widx < (CNT_W-2)'(HDR_WORDS)) begin
			if (widx == (CNT_W-2)'(IP_CSUM_WORD)) begin
				ip_add = IPS_W'(w[31:16]);
			end else begin
				ip_add = IPS_W'(halves);
			end
		end else if (widx == (CNT_W-2)'(ICMP_HDR_WORD)) begin
			icmp_add = ICS_W'(w[23:16]);
		end else begin
			icmp_add = ICS_W'(halves);
		end
	end

	assign cnt_nx  = take ? cnt_sum[CNT_W-1:0] : cnt_q;
	assign ip_nx   = take ? ip_q + ip_add : ip_q;
	assign icmp_nx = take ? icmp_q + icmp_add : icmp_q;
	assign ovf_nx  = ovf_q || set_ovf;

	// Store write
	assign wr.en   = acc && take;
	assign wr.addr = {bank_q, widx[IDX_W-1:0]};
	assign wr.data = w;

	// Hand the finished packet to the back
	assign push          = acc && echo.in_last;
	assign desc.bank     = bank_q;
	assign desc.nbytes   = cnt_nx;
	assign desc.ip_sum   = ip_nx;
	assign desc.icmp_sum = icmp_nx;
	always_comb begin
		if (ovf_nx) begin
			desc.status = ST_LONG;
		end else if (cnt_nx < CNT_W'(MIN_BYTES)) begin
			desc.status = ST_SHORT;
		end else begin
			desc.status = ST_REPLY;
		end
	end

	// Advance packet state, clear it after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			cnt_q  <= '0;
			ip_q   <= '0;
			icmp_q <= '0;
			ovf_q  <= 1'b0;
		end else if (acc) begin
			if (echo.in_last) begin
				bank_q <= ~bank_q;
				cnt_q  <= '0;
				ip_q   <= '0;
				icmp_q <= '0;
				ovf_q  <= 1'b0;
			end else begin
				cnt_q  <= cnt_nx;
				ip_q   <= ip_nx;
				icmp_q <= icmp_nx;
				ovf_q  <= ovf_nx;
			end
		end
	end

	// Next bank ownership: release from the back, claim on push
	always_comb begin
		busy_nx = busy_q;
		if (rel.valid) begin
			busy_nx[rel.bank] = 1'b0;
		end
		if (push) begin
			busy_nx[bank_q] = 1'b1;
		end
	end

	// Track banks owned by the queue or the back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 2'b00;
		end else begin
			busy_q <= busy_nx;
		end
	end

endmodule

// ----- sv/ier_queue.sv -----
// Two-entry queue of finished packet descriptors between front and back.
// Depends on ier_pkg.
module ier_queue
	import ier_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	input  logic  pop,
	output logic  full,
	output logic  not_empty,
	output desc_t head
);

	desc_t      ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head      = ent_q[rp_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wp_q] <= push_desc;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wp_q <= ~wp_q;
			end
			if (pop && not_empty) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
		end
	end

endmodule

// ----- sv/ier_back.sv -----
// Back part: replays a stored packet as the reply, or emits a drop result.
// Depends on ier_pkg and ier_out_if; reads ier_ram, pops ier_queue.
module ier_back
	import ier_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  desc_t        q_head,
	output logic         q_pop,
	output mem_rd_t      rd,
	input  logic [31:0]  rd_data,
	output release_t     rel,
	ier_out_if.source    reply
);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_RUN  = 2'd1;
	localparam logic [1:0] B_DROP = 2'd2;

	logic [1:0]       st_q;
	logic             bank_q;
	logic [IDX_W-1:0] last_idx_q;
	logic [2:0]       tail_q;
	logic [1:0]       status_q;
	logic [15:0]      ipc_q;
	logic [15:0]      icc_q;
	logic [IDX_W-1:0] ok_q;

	logic             out_valid_q;
	logic [31:0]      out_word_q;
	logic [2:0]       out_bytes_q;
	logic             out_last_q;
	logic [1:0]       out_status_q;

	logic             can_load;
	logic [CNT_W-1:0] nm1;
	logic             is_last;
	logic [31:0]      v;

	// Swap source and destination words on read
	function automatic logic [IDX_W-1:0] map_idx(input logic [IDX_W-1:0] k);
		logic [IDX_W-1:0] r;
		if (k == SRC_WORD) begin
			r = DST_WORD;
		end else if (k == DST_WORD) begin
			r = SRC_WORD;
		end else begin
			r = k;
		end
		return r;
	endfunction

	assign can_load = !out_valid_q || reply.ready;
	assign nm1      = q_head.nbytes - CNT_W'(1);
	assign is_last  = ok_q == last_idx_q;
	assign q_pop    = (st_q == B_IDLE) && q_valid;

	// Patch checksums and ICMP type, clear bytes past the tail
	always_comb begin
		v = rd_data;
		if (ok_q == IP_CSUM_WORD) begin
			v = {rd_data[31:16], ipc_q};
		end else if (ok_q == ICMP_HDR_WORD) begin
			v = {8'h00, rd_data[23:16], icc_q};
		end
		if (is_last) begin
			v = mask_bytes(v, tail_q);
		end
	end

	// Store reads: first word on job start, next word on each load
	always_comb begin
		rd.en   = 1'b0;
		rd.addr = {bank_q, map_idx(ok_q + IDX_W'(1))};
		if (st_q == B_IDLE) begin
			rd.en   = q_valid && (q_head.status == ST_REPLY);
			rd.addr = {q_head.bank, map_idx('0)};
		end else if (st_q == B_RUN) begin
			rd.en = can_load && !is_last;
		end
	end

	// Free the bank when the job's final result is loaded
	always_comb begin
		rel.bank  = bank_q;
		rel.valid = 1'b0;
		if (st_q == B_DROP) begin
			rel.valid = can_load;
		end else if (st_q == B_RUN) begin
			rel.valid = can_load && is_last;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			ok_q <= '0;
		end else begin
			unique case (st_q)
				B_IDLE: begin
					if (q_valid) begin
						ok_q <= '0;
						st_q <= (q_head.status == ST_REPLY) ? B_RUN : B_DROP;
					end
				end
				B_RUN: begin
					if (can_load) begin
						if (is_last) begin
							st_q <= B_IDLE;
						end else begin
							ok_q <= ok_q + IDX_W'(1);
						end
					end
				end
				B_DROP: begin
					if (can_load) begin
						st_q <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	// Latch the job and its folded checksums
	always_ff @(posedge clk) begin
		if (q_pop) begin
			bank_q     <= q_head.bank;
			status_q   <= q_head.status;
			last_idx_q <= nm1[IDX_W+1:2];
			tail_q     <= {1'b0, nm1[1:0]} + 3'd1;
			ipc_q      <= csum_fold(ICS_W'(q_head.ip_sum));
			icc_q      <= csum_fold(q_head.icmp_sum);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= (st_q == B_RUN) || (st_q == B_DROP);
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (can_load) begin
			if (st_q == B_DROP) begin
				out_word_q   <= 32'h0;
				out_bytes_q  <= 3'd0;
				out_last_q   <= 1'b1;
				out_status_q <= status_q;
			end else begin
				out_word_q   <= v;
				out_bytes_q  <= is_last ? tail_q : 3'd4;
				out_last_q   <= is_last;
				out_status_q <= ST_REPLY;
			end
		end
	end

	assign reply.valid      = out_valid_q;
	assign reply.out_word   = out_word_q;
	assign reply.out_bytes  = out_bytes_q;
	assign reply.out_last   = out_last_q;
	assign reply.out_status = out_status_q;

endmodule

// ----- dv/tb_icmp_echo_reply_rewriter.sv -----
`timescale 1ns / 1ps
// Self-checking bench for icmp_echo_reply_rewriter: directed table, then random echo packets.
// Depends on icmp_echo_reply_rewriter, ier_pkg, ier_in_if and ier_out_if; expected replies come from a local predictor.
module tb_icmp_echo_reply_rewriter
	import ier_pkg::*;
();

	localparam int RAND_ITEMS    = 320;
	localparam int QUIET_TAIL    = 40;
	localparam int LONG_HOLD     = 300;
	localparam int DRAIN_CYCLES  = 16;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int STORE_WORDS   = 64;
	localparam int IP_HDR_LEN    = 20;
	localparam int IP_CSUM_POS   = 10;
	localparam int ICMP_TYPE_POS = 20;
	localparam int ICMP_CSUM_POS = 22;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
		logic [1:0]  status;
	} reply_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
		bit          typed;
		logic [1:0]  status;
	} stim_row_t;

	typedef enum int {PK_SHORT, PK_NORMAL, PK_FULL, PK_LONG} pkt_kind_t;

	logic clk;
	logic arst_n;

	ier_in_if  echo ();
	ier_out_if reply ();

	icmp_echo_reply_rewriter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.echo   (echo),
		.reply  (reply)
	);

	// Predictor state: packet image, byte fill, running sums, overflow
	logic [31:0] img [STORE_WORDS];
	int          fill;
	logic [19:0] hdr_sum;
	logic [23:0] msg_sum;
	bit          too_long;

	reply_t    reply_due [$];
	stim_row_t dir_rows [$];
	int        mismatch_count;
	int        cycle_count;
	int        items_sent;
	bit        idle_on;
	bit        long_hold_req;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Fold a sum to 16 bits and invert
	function automatic logic [15:0] fold16(input logic [23:0] s);
		int unsigned t;
		t = 32'(s);
		while ((t >> 16) != 0)
			t = (t & 32'hFFFF) + (t >> 16);
		return ~t[15:0];
	endfunction

	// Add one byte to the IP header sum or the ICMP sum by its position
	function automatic void sum_byte(input int pos, input logic [7:0] b);
		logic [15:0] v;
		v = pos[0] ? {8'h00, b} : {b, 8'h00};
		if (pos < IP_HDR_LEN) begin
			if (pos != IP_CSUM_POS && pos != IP_CSUM_POS + 1)
				hdr_sum = hdr_sum + 20'(v);
		end else if (pos != ICMP_TYPE_POS && pos != ICMP_CSUM_POS && pos != ICMP_CSUM_POS + 1) begin
			msg_sum = msg_sum + 24'(v);
		end
	endfunction

	// Absorb one accepted request word; on the last word queue the packet's replies
	function automatic void absorb_echo_word(input logic [31:0] w_in, input logic [2:0] b_in,
			input logic last_in);
		logic [31:0] w;
		logic [31:0] v;
		int          nb;
		int          nw;
		int          cnt;
		logic [15:0] ip_cs;
		logic [15:0] icmp_cs;
		reply_t      r;
		w = w_in;
		nb = 4;
		if (last_in)
			nb = (b_in > 3'd4) ? 4 : int'(b_in);
		if (!too_long && nb > 0) begin
			if (fill + nb > MAX_BYTES) begin
				too_long = 1'b1;
			end else begin
				if (nb < 4)
					w = w & ~(32'hFFFF_FFFF >> (8 * nb));
				img[(fill >> 2) % STORE_WORDS] = w;
				for (int j = 0; j < nb; j++)
					sum_byte(fill + j, w[31 - 8 * j -: 8]);
				fill = fill + nb;
			end
		end
		if (!last_in)
			return;
		if (too_long || fill < MIN_BYTES) begin
			r.word   = 32'h0;
			r.nbytes = 3'd0;
			r.last   = 1'b1;
			r.status = too_long ? ST_LONG : ST_SHORT;
			reply_due.push_back(r);
		end else begin
			nw = (fill + 3) / 4;
			ip_cs = fold16({4'h0, hdr_sum});
			icmp_cs = fold16(msg_sum);
			for (int k = 0; k < nw; k++) begin
				// swap source and destination words
				if (k == 3)
					v = img[4];
				else if (k == 4)
					v = img[3];
				else
					v = img[k];
				if (k == 2)
					v = {v[31:16], ip_cs};
				if (k == 5)
					v = {8'h00, v[23:16], icmp_cs};
				cnt = 4;
				if (k == nw - 1) begin
					cnt = fill - 4 * k;
					if (cnt < 4)
						v = v & ~(32'hFFFF_FFFF >> (8 * cnt));
				end
				r.word   = v;
				r.nbytes = 3'(cnt);
				r.last   = (k == nw - 1);
				r.status = ST_REPLY;
				reply_due.push_back(r);
			end
		end
		fill = 0;
		hdr_sum = '0;
		msg_sum = '0;
		too_long = 1'b0;
	endfunction

	function automatic stim_row_t row(input logic [31:0] w, input logic [2:0] b, input logic l,
			input bit t, input logic [1:0] st);
		stim_row_t s;
		s.word = w;
		s.nbytes = b;
		s.last = l;
		s.typed = t;
		s.status = st;
		return s;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	// Offer one request word, hold it until accepted, then predict
	task automatic push_echo(input logic [31:0] w, input logic [2:0] b, input logic l,
			input bit typed, input logic [1:0] st);
		int     held;
		reply_t r;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			echo.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		echo.valid    <= 1'b1;
		echo.in_word  <= w;
		echo.in_bytes <= b;
		echo.in_last  <= l;
		@(posedge clk);
		while (!echo.ready)
			@(posedge clk);
		held = reply_due.size();
		absorb_echo_word(w, b, l);
		// replace the prediction with the typed-in drop where the row gives one
		if (typed) begin
			while (reply_due.size() > held)
				void'(reply_due.pop_back());
			r.word   = 32'h0;
			r.nbytes = 3'd0;
			r.last   = 1'b1;
			r.status = st;
			reply_due.push_back(r);
		end
		items_sent++;
	endtask

	// Send one packet of the given length; optionally close it with an empty last word
	task automatic push_packet(input int len, input bit empty_tail);
		int          nw;
		int          tail;
		logic [2:0]  b;
		logic [31:0] w;
		nw = (len + 3) / 4;
		for (int k = 0; k < nw; k++) begin
			case ($urandom_range(0, 9))
				0:       w = 32'h0000_0000;
				1:       w = 32'hFFFF_FFFF;
				default: w = $urandom;
			endcase
			if (k == 0 && $urandom_range(0, 1) == 0)
				w = {8'h45, w[23:0]};
			if (k == 5 && $urandom_range(0, 1) == 0)
				w = {8'h08, w[23:0]};
			if (k < nw - 1 || empty_tail) begin
				b = 3'($urandom_range(0, 7));
				push_echo(w, b, 1'b0, 1'b0, ST_REPLY);
			end else begin
				tail = len - 4 * k;
				b = 3'(tail);
				if (tail == 4 && $urandom_range(0, 2) == 0)
					b = 3'($urandom_range(5, 7));
				push_echo(w, b, 1'b1, 1'b0, ST_REPLY);
			end
		end
		if (empty_tail)
			push_echo($urandom, 3'd0, 1'b1, 1'b0, ST_REPLY);
	endtask

	// Result side: random ready bursts, one long hold on request
	initial begin
		reply.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				reply.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				reply.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				reply.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				reply.ready <= 1'b1;
			end else begin
				reply.ready <= 1'b1;
			end
		end
	end

	// Check every accepted result against the oldest expectation
	always @(posedge clk) begin
		reply_t e;
		if (arst_n === 1'b1 && reply.valid === 1'b1 && reply.ready === 1'b1) begin
			if (reply_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected result word %h status %0d",
					reply.out_word, reply.out_status));
			end else begin
				e = reply_due.pop_front();
				if (reply.out_word !== e.word)
					flag_mismatch($sformatf("out_word %h, want %h", reply.out_word, e.word));
				if (reply.out_bytes !== e.nbytes)
					flag_mismatch($sformatf("out_bytes %0d, want %0d", reply.out_bytes, e.nbytes));
				if (reply.out_last !== e.last)
					flag_mismatch($sformatf("out_last %b, want %b", reply.out_last, e.last));
				if (reply.out_status !== e.status)
					flag_mismatch($sformatf("out_status %0d, want %0d", reply.out_status, e.status));
			end
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		pkt_kind_t kind;
		int        pk;
		int        len;
		mismatch_count = 0;
		items_sent = 0;
		idle_on = 1'b1;
		long_hold_req = 1'b0;
		fill = 0;
		hdr_sum = '0;
		msg_sum = '0;
		too_long = 1'b0;
		arst_n = 1'b0;
		echo.valid    <= 1'b0;
		echo.in_word  <= 32'h0;
		echo.in_bytes <= 3'd0;
		echo.in_last  <= 1'b0;

		// Directed table: drops typed in, replies predicted
		dir_rows.push_back(row(32'h4500_0054, 3'd4, 1'b1, 1'b1, ST_SHORT));
		dir_rows.push_back(row(32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, ST_SHORT));
		dir_rows.push_back(row(32'h0000_0000, 3'd5, 1'b0, 1'b0, ST_REPLY));
		dir_rows.push_back(row(32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1, ST_SHORT));
		// 24 bytes of all ones; short counts on non-last words are ignored
		for (int k = 0; k < 5; k++)
			dir_rows.push_back(row(32'hFFFF_FFFF, 3'd1, 1'b0, 1'b0, ST_REPLY));
		dir_rows.push_back(row(32'hFFFF_FFFF, 3'd4, 1'b1, 1'b0, ST_REPLY));
		// 23 bytes: one short of the minimum
		for (int k = 0; k < 5; k++)
			dir_rows.push_back(row(32'h0000_0000, 3'd4, 1'b0, 1'b0, ST_REPLY));
		dir_rows.push_back(row(32'h0000_0000, 3'd3, 1'b1, 1'b1, ST_SHORT));
		// 25-byte echo request with an odd tail byte
		dir_rows.push_back(row(32'h4500_0019, 3'd6, 1'b0, 1'b0, ST_REPLY));
		dir_rows.push_back(row(32'h1C46_4000, 3'd4, 1'b0, 1'b0, ST_REPLY));
		dir_rows.push_back(row(32'h4001_B1E6, 3'd4, 1'b0, 1'b0, ST_REPLY));
		dir_rows.push_back(row(32'hC0A8_0001, 3'd4, 1'b0, 1'b0, ST_REPLY));
		dir_rows.push_back(row(32'hC0A8_00C7, 3'd4, 1'b0, 1'b0, ST_REPLY));
		dir_rows.push_back(row(32'h0800_F7FF, 3'd4, 1'b0, 1'b0, ST_REPLY));
		dir_rows.push_back(row(32'hABCD_EF01, 3'd1, 1'b1, 1'b0, ST_REPLY));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			push_echo(dir_rows[i].word, dir_rows[i].nbytes, dir_rows[i].last,
				dir_rows[i].typed, dir_rows[i].status);

		// Random packets: mostly well formed, some short, full and oversized
		items_sent = 0;
		pk = 0;
		while (items_sent < RAND_ITEMS) begin
			idle_on = (items_sent < RAND_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			if (pk == 1)
				kind = PK_FULL;
			else if (pk == 2)
				kind = PK_LONG;
			else
				case ($urandom_range(0, 19))
					0, 1:    kind = PK_SHORT;
					2:       kind = PK_FULL;
					3:       kind = PK_LONG;
					default: kind = PK_NORMAL;
				endcase
			case (kind)
				PK_SHORT: len = $urandom_range(1, MIN_BYTES - 1);
				PK_FULL:  len = MAX_BYTES;
				PK_LONG:  len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 12);
				default:  len = $urandom_range(MIN_BYTES, 64);
			endcase
			// hold the result side off while requests keep coming
			if (pk == 4)
				long_hold_req = 1'b1;
			// pause requests until every reply is in
			if (pk == 9 && reply_due.size() != 0) begin
				echo.valid <= 1'b0;
				while (reply_due.size() != 0)
					@(posedge clk);
			end
			push_packet(len, $urandom_range(0, 9) == 0);
			pk++;
		end

		echo.valid <= 1'b0;
		idle_on = 1'b0;
		while (reply_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
